// ===== hw/rtl/positional_ordered_list_top_assert.svh =====
// Assertion macros for the positional ordered list top level
`ifndef POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define POL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional ordered list: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define POL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional ordered list: next-cycle check failed");
`else
`define POL_ASSERT_SAME(label, ante, cons)
`define POL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/pol_pkg.sv =====
// Shared constants, codes and types of the positional ordered list
package pol_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_LOCATE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_CLOSE,
    ST_REPLY
  } state_t;

endpackage

// ===== hw/rtl/pol_in_if.sv =====
// Command channel: valid/ready handshake with command, position and value
interface pol_in_if;
  import pol_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== hw/rtl/pol_out_if.sv =====
// Result channel: valid/ready handshake with status, data, match and length
interface pol_out_if;
  import pol_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0]         found_position;
  logic [POS_W-1:0]         count;

  modport source (output valid, output status, output read_value, output found_position,
                  output count, input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input count, output ready);
endinterface

// ===== hw/rtl/pol_cell.sv =====
// One list cell: holds one entry and moves it to or from its neighbors
module pol_cell (
  input  logic                        clk,
  input  pol_pkg::cell_ctl_t          ctl,
  input  logic [pol_pkg::CNT_W-1:0]   cell_pos,
  input  logic [pol_pkg::DATA_W-1:0]  left_q,
  input  logic [pol_pkg::DATA_W-1:0]  right_q,
  output logic [pol_pkg::DATA_W-1:0]  entry_q
);
  import pol_pkg::*;

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      CELL_ROTATE: entry_nxt = right_q;
      CELL_OPEN: begin
        // new word lands here, later entries move up one place
        if (cell_pos == ctl.pos) begin
          entry_nxt = ctl.value;
        end else if (cell_pos > ctl.pos) begin
          entry_nxt = left_q;
        end
      end
      CELL_CLOSE: begin
        if (cell_pos >= ctl.pos) begin
          entry_nxt = right_q;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;
endmodule

// ===== hw/rtl/pol_chain.sv =====
// Row of list cells wired as a ring; cell 0 is the head seen by the controller
module pol_chain (
  input  logic                        clk,
  input  pol_pkg::cell_ctl_t          ctl,
  output logic [pol_pkg::DATA_W-1:0]  head_q
);
  import pol_pkg::*;

  logic [DATA_W-1:0] q [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int LEFT  = (g == 0) ? 0 : g - 1;
    localparam int RIGHT = (g + 1) % CAPACITY;

    pol_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cell_pos (CNT_W'(g + 1)),
      .left_q   (q[LEFT]),
      .right_q  (q[RIGHT]),
      .entry_q  (q[g])
    );
  end

  assign head_q = q[0];
endmodule

// ===== hw/rtl/positional_ordered_list_top.sv =====
// Positional ordered list: controller, cell ring and result register
//
//   port    | dir | word carried
//   --------+-----+--------------------------------------------------
//   in_ch   | in  | cmd, position, value
//   out_ch  | out | status, read_value, found_position, count
//
// Insert: decode with one parallel shift of the cell row in ST_EXEC, then ST_REPLY
// loads the result register; a command refused in decode goes straight to ST_REPLY.
// Get and locate: ST_EXEC, then one full rotation of the cell ring past the head
// cell in ST_SCAN, then ST_REPLY. Delete: the rotation, then one parallel shift
// down in ST_CLOSE. One command is in work at a time; a new word is taken while
// the previous result waits on out_ch.
// Reset (rst_n low, synchronous) empties the list; entries need no clearing.
`include "positional_ordered_list_top_assert.svh"

module positional_ordered_list_top (
  input logic        clk,
  input logic        rst_n,
  pol_in_if.sink     in_ch,
  pol_out_if.source  out_ch
);
  import pol_pkg::*;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;

  // command held for the whole operation
  cmd_t              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  // scan progress and pending result
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              found_r, found_nxt;
  status_t           st_r, st_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0]  fp_r, fp_nxt;

  // result register toward out_ch
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_rd_r, out_rd_nxt;
  logic [POS_W-1:0]  out_fp_r, out_fp_nxt;
  logic [POS_W-1:0]  out_cnt_r, out_cnt_nxt;

  cell_ctl_t         cell_ctl;
  logic [DATA_W-1:0] head_q;

  // range checks in a width that holds both position and length
  logic [CMP_W-1:0]  pos_w, len_w, k_w;
  logic              insert_bad, select_bad, list_full;

  assign pos_w      = CMP_W'(pos_r);
  assign len_w      = CMP_W'(len_r);
  assign k_w        = CMP_W'(k_r) + CMP_W'(1);
  assign insert_bad = (pos_w == '0) || (pos_w > len_w + CMP_W'(1));
  assign select_bad = (pos_w == '0) || (pos_w > len_w);
  assign list_full  = (len_r == CNT_W'(CAPACITY));

  pol_chain u_chain (
    .clk    (clk),
    .ctl    (cell_ctl),
    .head_q (head_q)
  );

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.read_value     = out_rd_r;
  assign out_ch.found_position = out_fp_r;
  assign out_ch.count          = out_cnt_r;

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    out_valid_nxt  = out_valid_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    k_nxt          = k_r;
    found_nxt      = found_r;
    st_nxt         = st_r;
    rd_nxt         = rd_r;
    fp_nxt         = fp_r;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_fp_nxt     = out_fp_r;
    out_cnt_nxt    = out_cnt_r;
    cell_ctl.op    = CELL_HOLD;
    cell_ctl.pos   = CNT_W'(pos_r);
    cell_ctl.value = val_r;

    // drop the result word once the sink takes it
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.cmd);
          pos_nxt   = in_ch.position;
          val_nxt   = in_ch.value;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // start every command from a clean result
        rd_nxt    = '0;
        fp_nxt    = '0;
        found_nxt = 1'b0;
        k_nxt     = '0;
        st_nxt    = STAT_OK;
        state_nxt = ST_REPLY;
        unique case (cmd_r) inside
          CMD_INSERT: begin
            if (insert_bad) begin
              st_nxt = STAT_RANGE;
            end else if (list_full) begin
              st_nxt = STAT_FULL;
            end else begin
              cell_ctl.op = CELL_OPEN;
              len_nxt     = len_r + CNT_W'(1);
            end
          end
          CMD_DELETE, CMD_GET: begin
            if (select_bad) begin
              st_nxt = STAT_RANGE;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          CMD_LOCATE: state_nxt = ST_SCAN;
        endcase
      end

      ST_SCAN: begin
        // entry k sits in the head cell; rotate the ring one place
        cell_ctl.op = CELL_ROTATE;
        k_nxt       = k_r + IDX_W'(1);
        if ((cmd_r != CMD_LOCATE) && (k_w == pos_w)) begin
          rd_nxt = head_q;
        end
        if ((cmd_r == CMD_LOCATE) && !found_r && (k_w <= len_w) && (head_q == val_r)) begin
          found_nxt = 1'b1;
          fp_nxt    = CNT_W'(k_w);
        end
        // a full turn puts every entry back in place
        if (k_r == IDX_W'(CAPACITY - 1)) begin
          if ((cmd_r == CMD_LOCATE) && !found_nxt) begin
            st_nxt = STAT_NOTFOUND;
          end
          state_nxt = (cmd_r == CMD_DELETE) ? ST_CLOSE : ST_REPLY;
        end
      end

      ST_CLOSE: begin
        cell_ctl.op = CELL_CLOSE;
        len_nxt     = len_r - CNT_W'(1);
        state_nxt   = ST_REPLY;
      end

      ST_REPLY: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_rd_nxt     = rd_r;
          out_fp_nxt     = POS_W'(fp_r);
          out_cnt_nxt    = POS_W'(len_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    k_r          <= k_nxt;
    found_r      <= found_nxt;
    st_r         <= st_nxt;
    rd_r         <= rd_nxt;
    fp_r         <= fp_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_fp_r     <= out_fp_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // length never passes the number of cells
  `POL_ASSERT_SAME(a_len_bound, 1'b1, len_r <= CNT_W'(CAPACITY))
  // an accepted word is decoded in the next cycle
  `POL_ASSERT_NEXT(a_accept_exec, in_ch.valid && in_ch.ready, state_r == ST_EXEC)
  // a rotation never changes the length
  `POL_ASSERT_NEXT(a_scan_len, state_r == ST_SCAN, $stable(len_r))
  // a result word appears only out of the reply state
  `POL_ASSERT_NEXT(a_out_source, !out_valid_r && state_r != ST_REPLY, !out_valid_r)

endmodule
